### rtl/bqual_pkg.sv
// Shared types and constants for the encoder and button qualifier.
// No dependencies; every other file imports this package.
package bqual_pkg;

	// Width of the tick counters and thresholds
	localparam int TICK_W = 8;
	localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;

	// Threshold reset values
	localparam logic [TICK_W-1:0] PRESS_THRESHOLD_RESET = 8'd10;
	localparam logic [TICK_W-1:0] RELEASE_THRESHOLD_RESET = 8'd50;

	// Register indexes on the configuration channel
	localparam logic REG_PRESS_THRESHOLD = 1'b0;
	localparam logic REG_RELEASE_THRESHOLD = 1'b1;

	// Encoder phase pair coding: A is bit 0, B is bit 1
	localparam logic [1:0] PHASE_A_BIT = 2'b01;
	localparam logic [1:0] PHASE_B_BIT = 2'b10;
	localparam logic [1:0] DETENT_LOW = 2'b00;
	localparam logic [1:0] DETENT_HIGH = 2'b11;

	// Stream word widths
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 8;

	// Debouncer result for one tick
	typedef struct packed {
		logic button_event;
		logic button_pressed;
	} btn_res_t;

	// Encoder result for one tick
	typedef struct packed {
		logic step_event;
		logic step_direction;
		logic step_undecided;
	} step_res_t;

endpackage

### rtl/bqual_debounce.sv
// Asymmetric push-button debouncer with saturating tick counters.
// Depends on bqual_pkg.
module bqual_debounce (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic                         button_level,
	input  logic [bqual_pkg::TICK_W-1:0] press_threshold,
	input  logic [bqual_pkg::TICK_W-1:0] release_threshold,
	output bqual_pkg::btn_res_t          res
);
	import bqual_pkg::*;

	logic              released_q;
	logic [TICK_W-1:0] pressed_ticks_q;
	logic [TICK_W-1:0] released_ticks_q;

	logic              rel_2, rel_4;
	logic [TICK_W-1:0] p_1, p_3, p_4;
	logic [TICK_W-1:0] r_1, r_2, r_3;

	// Work through press counting, press decision, release counting, release decision
	always_comb begin
		// pressed tick: count up, drop the released run
		if (!button_level) begin
			p_1 = (pressed_ticks_q == TICK_MAX) ? TICK_MAX : pressed_ticks_q + 1'b1;
			r_1 = '0;
		end else begin
			p_1 = pressed_ticks_q;
			r_1 = released_ticks_q;
		end
		// declare a press
		if (p_1 > press_threshold && released_q) begin
			rel_2 = 1'b0;
			r_2 = '0;
		end else begin
			rel_2 = released_q;
			r_2 = r_1;
		end
		// released tick: count up, drop the pressed run
		if (button_level) begin
			r_3 = (r_2 == TICK_MAX) ? TICK_MAX : r_2 + 1'b1;
			p_3 = '0;
		end else begin
			r_3 = r_2;
			p_3 = p_1;
		end
		// declare a release
		if (r_3 > release_threshold && !rel_2) begin
			rel_4 = 1'b1;
			p_4 = '0;
		end else begin
			rel_4 = rel_2;
			p_4 = p_3;
		end
	end

	assign res.button_event = rel_4 != released_q;
	assign res.button_pressed = !rel_4;

	// Advance the debouncer state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= 1'b1;
			pressed_ticks_q <= '0;
			released_ticks_q <= '0;
		end else if (tick) begin
			released_q <= rel_4;
			pressed_ticks_q <= p_4;
			released_ticks_q <= r_3;
		end
	end

	// At most one of the two runs is in progress after any tick
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (pressed_ticks_q == '0) || (released_ticks_q == '0))
		else $error("both tick counters non-zero");

	// A state change only ever follows a tick
	a_change_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(released_q))
		else $error("debounced state changed without a tick");

	// A counter that changed was advanced by a tick
	a_count_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(pressed_ticks_q) && $stable(released_ticks_q))
		else $error("tick counter moved without a tick");

endmodule

### rtl/bqual_encoder.sv
// Quadrature encoder step detector working from detents 0 and 3.
// Depends on bqual_pkg.
module bqual_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 phase_a,
	input  logic                 phase_b,
	output bqual_pkg::step_res_t res
);
	import bqual_pkg::*;

	logic [1:0] last_q;
	logic [1:0] pair;

	assign pair = (phase_a ? PHASE_A_BIT : 2'b00) | (phase_b ? PHASE_B_BIT : 2'b00);

	// Report a step when the pair leaves a detent
	always_comb begin
		res = '0;
		if (pair != last_q) begin
			if (last_q == DETENT_LOW) begin
				res.step_event = 1'b1;
				res.step_direction = pair == PHASE_A_BIT;
				res.step_undecided = pair == DETENT_HIGH;
			end else if (last_q == DETENT_HIGH) begin
				res.step_event = 1'b1;
				res.step_direction = pair == PHASE_B_BIT;
				res.step_undecided = pair == DETENT_LOW;
			end
		end
	end

	// Hold the previous pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= DETENT_LOW;
		end else if (tick) begin
			last_q <= pair;
		end
	end

	// Direction and undecided never come together
	a_dir_xor_und: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.step_direction && res.step_undecided))
		else $error("step both directed and undecided");

	// A qualifier only comes with a step
	a_qual_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res.step_direction || res.step_undecided) |-> res.step_event)
		else $error("step qualifier without step event");

	// The pair held is the pair taken on the last tick
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> last_q == $past(pair))
		else $error("last phase pair not updated");

endmodule

### rtl/encoder_and_button_qualifier.sv
// Top level of the encoder and button qualifier: configuration registers,
// stream handshake and result register. Depends on bqual_pkg, bqual_debounce, bqual_encoder.
//
// Each input word is one sampling tick. The block accepts one word every clock cycle
// and returns exactly one result word per tick, in the cycle after acceptance, from a
// single output register; it keeps accepting while that register drains, and stalls
// only while a result waits and the downstream side is not ready. The debouncer and
// encoder state update in the cycle the word is accepted. Thresholds reset to 10 and
// 50 and are written through the configuration channel (index 0 press, 1 release),
// which is always ready; write them only while no tick is in flight.
module encoder_and_button_qualifier (
	input  logic                             clk,
	input  logic                             arst_n,
	// Sampling ticks
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// bit 0 button_level, bit 1 phase_a, bit 2 phase_b, bits 7:3 zero
	input  logic [bqual_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Results
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// bit 0 button_event, bit 1 button_pressed, bit 2 step_event,
	// bit 3 step_direction, bit 4 step_undecided, bits 7:5 zero
	output logic [bqual_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [bqual_pkg::TICK_W-1:0]     cfg_data
);
	import bqual_pkg::*;

	logic              tick;
	logic [TICK_W-1:0] press_threshold_q;
	logic [TICK_W-1:0] release_threshold_q;
	logic              out_valid_q;
	logic [4:0]        out_data_q;
	btn_res_t          btn_res;
	step_res_t         step_res;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign tick = s_axis_tvalid && s_axis_tready;

	// Hold the thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_threshold_q <= PRESS_THRESHOLD_RESET;
			release_threshold_q <= RELEASE_THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PRESS_THRESHOLD:   press_threshold_q <= cfg_data;
				REG_RELEASE_THRESHOLD: release_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bqual_debounce u_debounce (
		.clk               (clk),
		.arst_n            (arst_n),
		.tick              (tick),
		.button_level      (s_axis_tdata[0]),
		.press_threshold   (press_threshold_q),
		.release_threshold (release_threshold_q),
		.res               (btn_res)
	);

	bqual_encoder u_encoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.phase_a (s_axis_tdata[1]),
		.phase_b (s_axis_tdata[2]),
		.res     (step_res)
	);

	// Result register: load on a tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_data_q <= {step_res.step_undecided, step_res.step_direction,
				step_res.step_event, btn_res.button_pressed, btn_res.button_event};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_DATA_W-5){1'b0}}, out_data_q};

	// Every accepted tick leaves a result waiting
	a_tick_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> m_axis_tvalid)
		else $error("accepted tick produced no result word");

	// An undecided step is a step without direction
	a_undecided_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[2] && !m_axis_tdata[3]))
		else $error("undecided step word malformed");

	// A result is dropped only once taken or replaced
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted over an untaken result");

endmodule
